/* design/pcmrs_pkg.sv */
package pcmrs_pkg;

    localparam int PCMRS_PHASE_FRAC_BITS = 24;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIG_ENDIAN    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_STEP     = 2'd2;

    localparam logic [1:0] FMT_MONO16   = 2'd0;
    localparam logic [1:0] FMT_STEREO16 = 2'd1;
    localparam logic [1:0] FMT_STEREO24 = 2'd2;

    typedef struct packed {
        logic take;
        logic store_first;
        logic skip;
        logic mul;
        logic emit;
        logic bypass;
    } pcmrs_cmd_t;

    typedef struct packed {
        logic frame_done;
        logic bypass_mode;
        logic prev_valid;
        logic phase_ge_one;
        logic sum_ge_one;
        logic out_free;
    } pcmrs_status_t;

endpackage

/* design/pcmrs_ctrl.sv */
module pcmrs_ctrl
    import pcmrs_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  pcmrs_status_t status,
    output pcmrs_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_OUT,
        ST_BYPASS
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.take = s_tvalid;
                if (s_tvalid && status.frame_done) begin
                    state_next = status.bypass_mode ? ST_BYPASS : ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!status.prev_valid) begin
                    cmd.store_first = 1'b1;
                    state_next      = ST_IDLE;
                end else if (status.phase_ge_one) begin
                    cmd.skip   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = status.sum_ge_one ? ST_IDLE : ST_MUL;
                end
            end
            ST_BYPASS: begin
                if (status.out_free) begin
                    cmd.bypass = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/pcmrs_datapath.sv */
module pcmrs_datapath
    import pcmrs_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = PCMRS_PHASE_FRAC_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [7:0]                 s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,
    output logic                       m_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [PHASE_FRAC_BITS:0]   cfg_data,
    input  pcmrs_cmd_t                 cmd,
    output pcmrs_status_t              status
);

    localparam int F  = PHASE_FRAC_BITS;
    localparam int PW = F + 2;
    localparam int SW = F + 1;
    localparam int NW = F + 18;
    localparam longint unsigned ONE_L   = 64'd1 << F;
    localparam longint unsigned STEP_LO = (ONE_L * 99 + 99) / 100;
    localparam longint unsigned STEP_HI = (ONE_L * 101) / 100;
    localparam logic [PW-1:0] PHASE_ONE = PW'(ONE_L);
    localparam logic [SW-1:0] STEP_ONE  = SW'(ONE_L);
    localparam logic [SW-1:0] STEP_MIN  = SW'(STEP_LO);
    localparam logic [SW-1:0] STEP_MAX  = SW'(STEP_HI);

    logic [1:0]     fmt_reg;
    logic           big_reg;
    logic [SW-1:0]  step_reg;

    logic [2:0]     byte_pos_reg;
    logic [7:0]     hold_reg [2];
    logic [15:0]    left_hold_reg;
    logic [31:0]    cur_frame_reg;
    logic [31:0]    prev_frame_reg;
    logic           prev_valid_reg;
    logic [PW-1:0]  phase_reg;
    logic signed [NW-1:0] prod_reg [2];

    logic [31:0]    out_data_reg;
    logic           out_last_reg;
    logic           out_valid_reg;

    logic           mono;
    logic           is24;
    logic [2:0]     bpf;
    logic [2:0]     pos;
    logic [2:0]     pos_inc;
    logic [2:0]     pos_next;
    logic [1:0]     k;
    logic           sidx;
    logic           sample_end;
    logic [15:0]    sample;
    logic           frame_done;
    logic [31:0]    frame;

    logic [SW-1:0]  step_clamped;
    logic [PW-1:0]  phase_sum;
    logic           sum_ge_one;
    logic           out_free;

    logic signed [NW-1:0] prod_next [2];
    logic [15:0]          lerp_res  [2];

    assign cfg_ready = 1'b1;

    always_comb begin
        mono    = (fmt_reg == FMT_MONO16);
        is24    = (fmt_reg == FMT_STEREO24);
        bpf     = mono ? 3'd2 : (is24 ? 3'd6 : 3'd4);
        pos     = (byte_pos_reg >= bpf) ? 3'd0 : byte_pos_reg;
        pos_inc = pos + 3'd1;
        pos_next = (pos_inc >= bpf) ? 3'd0 : pos_inc;
        if (is24) begin
            sidx       = (pos >= 3'd3);
            k          = sidx ? 2'(pos - 3'd3) : pos[1:0];
            sample_end = (k == 2'd2);
            sample     = big_reg ? {hold_reg[0], hold_reg[1]} : {s_tdata, hold_reg[1]};
        end else begin
            sidx       = pos[1];
            k          = {1'b0, pos[0]};
            sample_end = pos[0];
            sample     = big_reg ? {hold_reg[0], s_tdata} : {s_tdata, hold_reg[0]};
        end
        frame_done = sample_end && (mono || sidx);
        frame      = mono ? {sample, sample} : {left_hold_reg, sample};
    end

    always_comb begin
        if (step_reg < STEP_MIN) begin
            step_clamped = STEP_MIN;
        end else if (step_reg > STEP_MAX) begin
            step_clamped = STEP_MAX;
        end else begin
            step_clamped = step_reg;
        end
        phase_sum  = phase_reg + {1'b0, step_clamped};
        sum_ge_one = (phase_sum >= PHASE_ONE);
        out_free   = !out_valid_reg || m_tready;
    end

    always_comb begin
        logic signed [16:0]   d;
        logic signed [NW-1:0] d_ext;
        logic signed [NW-1:0] frac_ext;
        logic signed [NW-1:0] a_ext;
        logic signed [NW-1:0] num;
        logic signed [NW-1:0] q;
        logic [15:0]          a;
        logic [15:0]          b;
        logic                 corr;
        for (int l = 0; l < 2; l++) begin
            a        = prev_frame_reg[16*l +: 16];
            b        = cur_frame_reg[16*l +: 16];
            d        = $signed({b[15], b}) - $signed({a[15], a});
            d_ext    = NW'(d);
            frac_ext = $signed(NW'({1'b0, phase_reg[F-1:0]}));
            prod_next[l] = d_ext * frac_ext;
            a_ext    = $signed({{(NW-16){a[15]}}, a});
            num      = (a_ext <<< F) + prod_reg[l];
            q        = num >>> F;
            corr     = num[NW-1] && (|num[F-1:0]);
            lerp_res[l] = q[15:0] + {15'd0, corr};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg  <= FMT_STEREO16;
            big_reg  <= 1'b0;
            step_reg <= STEP_ONE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SAMPLE_FORMAT: fmt_reg  <= cfg_data[1:0];
                REG_BIG_ENDIAN:    big_reg  <= cfg_data[0];
                REG_RATE_STEP:     step_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg   <= 3'd0;
            hold_reg[0]    <= 8'd0;
            hold_reg[1]    <= 8'd0;
            left_hold_reg  <= 16'd0;
            prev_frame_reg <= 32'd0;
            prev_valid_reg <= 1'b0;
            phase_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.take) begin
                byte_pos_reg <= pos_next;
                if (!sample_end) begin
                    hold_reg[k[0]] <= s_tdata;
                end else if (!mono && !sidx) begin
                    left_hold_reg <= sample;
                end
            end
            if (cmd.store_first) begin
                prev_frame_reg <= cur_frame_reg;
                prev_valid_reg <= 1'b1;
            end
            if (cmd.skip) begin
                prev_frame_reg <= cur_frame_reg;
                phase_reg      <= phase_reg - PHASE_ONE;
            end
            if (cmd.emit) begin
                phase_reg <= sum_ge_one ? phase_sum - PHASE_ONE : phase_sum;
                if (sum_ge_one) begin
                    prev_frame_reg <= cur_frame_reg;
                end
            end
            if (cmd.bypass) begin
                prev_valid_reg <= 1'b0;
                phase_reg      <= '0;
            end
            if (cmd.emit || cmd.bypass) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && frame_done) begin
            cur_frame_reg <= frame;
        end
        if (cmd.mul) begin
            prod_reg[0] <= prod_next[0];
            prod_reg[1] <= prod_next[1];
        end
        if (cmd.emit) begin
            out_data_reg <= {lerp_res[0], lerp_res[1]};
            out_last_reg <= sum_ge_one;
        end else if (cmd.bypass) begin
            out_data_reg <= {cur_frame_reg[15:0], cur_frame_reg[31:16]};
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign status.frame_done   = frame_done;
    assign status.bypass_mode  = (step_reg == STEP_ONE);
    assign status.prev_valid   = prev_valid_reg;
    assign status.phase_ge_one = (phase_reg >= PHASE_ONE);
    assign status.sum_ge_one   = sum_ge_one;
    assign status.out_free     = out_free;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit || cmd.bypass) |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a pending transaction");

    a_mul_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |-> (phase_reg < PHASE_ONE))
        else $error("interpolation started at phase of one or more");

    a_second_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && !sum_ge_one) |=> (phase_reg < PHASE_ONE))
        else $error("second result scheduled past phase one");

    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < (PHASE_ONE << 1))
        else $error("phase exceeded two");

    a_first_store: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_first |-> !prev_valid_reg)
        else $error("first frame stored while a frame is held");
`endif

endmodule

/* design/pcm_normalize_lerp_resampler.sv */
// PCM byte stream to stereo 16-bit frames with linear-interpolation rate adaptation.
// Input channel (s_*): one raw PCM byte per transaction in s_tdata.
// Output channel (m_*): one stereo sample pair per transaction; m_tlast marks the
// final result caused by an input byte. Each frame yields zero, one or two results.
// Configuration channel (cfg_*): register index and data; always ready. Write only
// while no byte is in flight.
// Sequence: a byte that does not complete a frame is only taken. A completing byte
// then passes a decide state, or the bypass state in bypass; the first held frame
// and a skip end in the decide state. Each interpolated result, one or two, passes
// a multiply state and then an output state that loads the output register. A result
// appears on m_* in the cycle after it is computed.
// Reset: format 16-bit stereo, little-endian, step of one (bypass), phase zero,
// no frame held, byte position at the start of a frame.
// Stall: the output register holds one result; the next byte is taken while it
// waits, and processing halts when a further result is ready and m_tready is low.
module pcm_normalize_lerp_resampler
    import pcmrs_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = PCMRS_PHASE_FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // data_byte
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [31:0]              m_tdata,   // right_sample, left_sample
    output logic                     m_tlast,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [PHASE_FRAC_BITS:0] cfg_data
);

    pcmrs_cmd_t    cmd;
    pcmrs_status_t status;

    pcmrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcmrs_datapath #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* sim/pcmrs_checker.sv */
module pcmrs_checker
    import pcmrs_pkg::*;
#(
    parameter int FRAC = PCMRS_PHASE_FRAC_BITS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  logic [31:0]     m_tdata,
    input  logic            m_tlast,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [FRAC:0]   cfg_data,
    output int              mismatches,
    output int              pending
);

    localparam longint UNITY    = longint'(1) << FRAC;
    localparam longint STEP_MIN = (UNITY * 99 + 99) / 100;
    localparam longint STEP_MAX = (UNITY * 101) / 100;

    typedef logic [FRAC:0] step_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        last;
    } pair_t;

    pair_t       pairs_due[$];
    int          fail_count;

    logic [1:0]  fmt;
    logic        big_end;
    logic [FRAC:0] step_reg;

    logic [2:0]  byte_pos;
    logic [7:0]  held [2];
    logic [15:0] left_keep;
    logic [15:0] prev_l;
    logic [15:0] prev_r;
    logic        prev_ok;
    longint      phase_acc;

    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input longint p);
        longint sa;
        longint sb;
        longint num;
        logic [15:0] q;
        sa  = longint'($signed(a));
        sb  = longint'($signed(b));
        num = sa * UNITY + (sb - sa) * p;
        q   = 16'(num / UNITY);
        return q;
    endfunction

    task automatic take_byte(input logic [7:0] b);
        int          frame_len;
        int          samp_len;
        int          pos;
        int          k;
        int          sidx;
        int          n;
        logic        mono;
        logic [15:0] s;
        logic [15:0] l;
        logic [15:0] r;
        longint      st;
        longint      nxt;
        pair_t       res;
        mono      = (fmt == FMT_MONO16);
        samp_len  = (fmt == FMT_STEREO24) ? 3 : 2;
        frame_len = mono ? 2 : samp_len * 2;
        if (byte_pos >= frame_len) begin
            byte_pos = '0;
        end
        pos      = byte_pos;
        byte_pos = 3'((pos + 1 >= frame_len) ? 0 : pos + 1);
        k        = pos % samp_len;
        sidx     = pos / samp_len;
        if (k + 1 < samp_len) begin
            held[k] = b;
        end else begin
            if (samp_len == 2) begin
                s = big_end ? {held[0], b} : {b, held[0]};
            end else begin
                s = big_end ? {held[0], held[1]} : {b, held[1]};
            end
            if (!mono && sidx == 0) begin
                left_keep = s;
            end else begin
                l = mono ? s : left_keep;
                r = s;
                if (step_reg == UNITY) begin
                    prev_ok   = 1'b0;
                    phase_acc = 0;
                    res = '{left: l, right: r, last: 1'b1};
                    pairs_due.push_back(res);
                end else if (!prev_ok) begin
                    prev_l  = l;
                    prev_r  = r;
                    prev_ok = 1'b1;
                end else begin
                    st = step_reg;
                    if (st < STEP_MIN) st = STEP_MIN;
                    if (st > STEP_MAX) st = STEP_MAX;
                    n = 0;
                    while (phase_acc < UNITY && n < 2) begin
                        nxt = phase_acc + st;
                        n++;
                        res.left  = blend(prev_l, l, phase_acc);
                        res.right = blend(prev_r, r, phase_acc);
                        res.last  = (nxt >= UNITY) || (n == 2);
                        pairs_due.push_back(res);
                        phase_acc = nxt;
                    end
                    phase_acc = (phase_acc >= UNITY) ? phase_acc - UNITY : 0;
                    prev_l = l;
                    prev_r = r;
                end
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        pair_t want;
        if (!aresetn) begin
            fmt       = FMT_STEREO16;
            big_end   = 1'b0;
            step_reg  = step_t'(UNITY);
            byte_pos  = '0;
            held[0]   = '0;
            held[1]   = '0;
            left_keep = '0;
            prev_l    = '0;
            prev_r    = '0;
            prev_ok   = 1'b0;
            phase_acc = 0;
            pairs_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pairs_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: unexpected transaction L=%0d R=%0d last=%0b",
                                 $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast);
                    end
                end else begin
                    want = pairs_due.pop_front();
                    if (m_tdata[15:0] !== want.left || m_tdata[31:16] !== want.right
                            || m_tlast !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                                     $signed(want.left), $signed(want.right), want.last,
                                     $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SAMPLE_FORMAT: fmt      = cfg_data[1:0];
                    REG_BIG_ENDIAN:    big_end  = cfg_data[0];
                    REG_RATE_STEP:     step_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata);
            end
        end
        pending    <= pairs_due.size();
        mismatches <= fail_count;
    end

endmodule

/* sim/tb_pcm_normalize_lerp_resampler.sv */
module tb_pcm_normalize_lerp_resampler;
    import pcmrs_pkg::*;

    localparam int     FRAC        = PCMRS_PHASE_FRAC_BITS;
    localparam longint UNITY       = longint'(1) << FRAC;
    localparam longint STEP_MIN    = (UNITY * 99 + 99) / 100;
    localparam longint STEP_MAX    = (UNITY * 101) / 100;
    localparam logic [1:0] FMT_UNDEFINED = 2'd3;
    localparam int     STALL_LIMIT = 2000;
    localparam int     RANDOM_BYTES = 1000;

    typedef logic [FRAC:0] cfg_word_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [31:0]            m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [FRAC:0]          cfg_data  = '0;

    int chk_errors;
    int chk_pending;
    int burst_left  = 0;
    int bytes_sent  = 0;
    int idle_cycles = 0;
    int cyc         = 0;
    int rdy_mode    = 0;
    int rdy_left    = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pcm_normalize_lerp_resampler #(
        .PHASE_FRAC_BITS(FRAC)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pcmrs_checker #(
        .FRAC(FRAC)
    ) chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (chk_errors),
        .pending    (chk_pending)
    );

    // receiver backpressure: random choice among four ready patterns
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (rdy_left == 0) begin
            rdy_mode <= $urandom_range(0, 3);
            rdy_left <= $urandom_range(16, 200);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= cyc[2];
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic push_word(input logic [31:0] w, input int n);
        for (int i = 0; i < n; i++) begin
            push_byte(w[8*i +: 8]);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [FRAC:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // drain all expected results, then let any resultless byte finish
    task automatic quiesce;
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge aclk);
        while (chk_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        int            len;
        logic [FRAC:0] step;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // stereo 16-bit little-endian bypass, sample extremes
        push_word(32'h7FFF_8000, 4);
        quiesce;
        write_reg(REG_SAMPLE_FORMAT, cfg_word_t'(FMT_MONO16));
        write_reg(REG_BIG_ENDIAN, cfg_word_t'(1'b1));
        cfg_valid <= 1'b0;
        push_word(32'hFF7F_0080, 4);
        push_byte(8'h12);
        // flip byte order mid-sample
        quiesce;
        write_reg(REG_BIG_ENDIAN, cfg_word_t'(1'b0));
        cfg_valid <= 1'b0;
        push_byte(8'h34);
        quiesce;
        write_reg(REG_SAMPLE_FORMAT, cfg_word_t'(FMT_STEREO24));
        cfg_valid <= 1'b0;
        push_word(32'h4433_2211, 4);
        push_byte(8'h55);
        // format change mid-frame, step below range
        quiesce;
        write_reg(REG_SAMPLE_FORMAT, cfg_word_t'(FMT_MONO16));
        write_reg(REG_RATE_STEP, '0);
        cfg_valid <= 1'b0;
        push_word(32'h7FFF_8000, 4);
        quiesce;
        write_reg(REG_RATE_STEP, '1);
        cfg_valid <= 1'b0;
        push_word(32'h8000_7FFF, 4);
        quiesce;
        write_reg(REG_SAMPLE_FORMAT, cfg_word_t'(FMT_UNDEFINED));
        write_reg(REG_RATE_STEP, cfg_word_t'(UNITY));
        cfg_valid <= 1'b0;
        push_word(32'hA55A_01FE, 4);

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            quiesce;
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_SAMPLE_FORMAT, cfg_word_t'($urandom_range(0, 3)));
            end
            if ($urandom_range(0, 2) == 0) begin
                write_reg(REG_BIG_ENDIAN, cfg_word_t'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: step = cfg_word_t'(UNITY);
                    3:       step = '0;
                    4:       step = '1;
                    5:       step = cfg_word_t'(STEP_MIN);
                    6:       step = cfg_word_t'(STEP_MAX);
                    7:       step = cfg_word_t'($urandom_range(32'(STEP_MIN - 2000),
                                                               32'(STEP_MAX + 2000)));
                    default: step = cfg_word_t'($urandom_range(32'(STEP_MIN),
                                                               32'(STEP_MAX)));
                endcase
                write_reg(REG_RATE_STEP, step);
            end
            cfg_valid <= 1'b0;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : $urandom_range(20, 120);
            repeat (len) push_byte(8'($urandom_range(0, 255)));
        end

        quiesce;
        @(negedge aclk);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
design/pcmrs_pkg.sv
design/pcmrs_ctrl.sv
design/pcmrs_datapath.sv
design/pcm_normalize_lerp_resampler.sv
sim/pcmrs_checker.sv
sim/tb_pcm_normalize_lerp_resampler.sv
